// ===== rtl/core/sorted_key_set_core_macros.svh =====
// assertion macros for the sorted key set checker
// expects signals named clk and rst_n in the scope of use
`ifndef SORTED_KEY_SET_CORE_MACROS_SVH
`define SORTED_KEY_SET_CORE_MACROS_SVH

// same-cycle implication
`define SKS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted key set check failed");

// next-cycle implication
`define SKS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted key set check failed");

`endif

// ===== rtl/core/sks_pkg.sv =====
// shared types, constants and codes of the sorted key set
// no dependencies
`default_nettype none

package sks_pkg;

    localparam int CAPACITY    = 64;
    localparam int KEY_W       = 32;
    localparam int KIND_W      = 2;
    localparam int COUNT_OUT_W = 7;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    // match flags are ored in groups, one registered level
    localparam int GRP_SIZE    = 8;
    localparam int NGRP        = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic [CNT_W-1:0] count_t;

    localparam key_t INT_MAX = 32'sh7FFF_FFFF;
    localparam key_t INT_MIN = 32'sh8000_0000;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD      = 2'd0,
        KIND_REMOVE   = 2'd1,
        KIND_CONTAINS = 2'd2,
        KIND_CLEAR    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_CLEAR  = 2'd3
    } cell_op_t;

    typedef struct packed {
        logic     compare;
        cell_op_t op;
    } cell_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/sks_if.sv =====
// valid/ready channel interfaces for request and response items
// depends on sks_pkg
`default_nettype none

interface sks_req_if;
    import sks_pkg::*;
    logic  valid;
    logic  ready;
    kind_t kind;
    key_t  key;

    modport source (output valid, output kind, output key, input ready);
    modport sink (input valid, input kind, input key, output ready);
endinterface

interface sks_rsp_if;
    import sks_pkg::*;
    logic                   valid;
    logic                   ready;
    logic                   success;
    logic                   full_reject;
    logic [COUNT_OUT_W-1:0] entry_count;

    modport source (output valid, output success, output full_reject,
                    output entry_count, input ready);
    modport sink (input valid, input success, input full_reject,
                  input entry_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sks_cell.sv =====
// one position of the sorted chain: key, valid mark and compare flags
// depends on sks_pkg
`default_nettype none

module sks_cell
    import sks_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cell_cmd_t cmd,
    input  wire key_t      cmp_key,
    input  wire key_t      ins_key,
    input  wire key_t      left_key,
    input  wire logic      left_valid,
    input  wire logic      left_lt,
    input  wire key_t      right_key,
    input  wire logic      right_valid,
    output key_t           key,
    output logic           valid,
    output logic           lt,
    output logic           eq
);

    key_t key_reg, key_next;
    logic valid_reg, valid_next;
    logic lt_reg, lt_next;
    logic eq_reg, eq_next;

    always_comb
    begin
        key_next   = key_reg;
        valid_next = valid_reg;
        lt_next    = lt_reg;
        eq_next    = eq_reg;
        if (cmd.compare)
        begin
            lt_next = valid_reg && (key_reg < cmp_key);
            eq_next = valid_reg && (key_reg == cmp_key);
        end
        case (cmd.op)
            OP_INSERT:
            begin
                // cells at or above the slot move up by one
                if (!lt_reg)
                begin
                    key_next   = left_lt ? ins_key : left_key;
                    valid_next = valid_reg | left_valid;
                end
            end
            OP_DELETE:
            begin
                if (!lt_reg)
                begin
                    key_next   = right_key;
                    valid_next = right_valid;
                end
            end
            OP_CLEAR:
            begin
                valid_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            lt_reg    <= 1'b0;
            eq_reg    <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            lt_reg    <= lt_next;
            eq_reg    <= eq_next;
        end
    end

    assign key   = key_reg;
    assign valid = valid_reg;
    assign lt    = lt_reg;
    assign eq    = eq_reg;

endmodule

`default_nettype wire

// ===== rtl/core/sks_chain.sv =====
// row of sks_cell instances wired to their neighbours, plus grouped match flags
// depends on sks_pkg and sks_cell
`default_nettype none

module sks_chain
    import sks_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cell_cmd_t cmd,
    input  wire key_t      cmp_key,
    input  wire key_t      ins_key,
    output logic [NGRP-1:0] grp_hit
);

    key_t                cell_key [CAPACITY];
    logic [CAPACITY-1:0] cell_valid;
    logic [CAPACITY-1:0] cell_lt;
    logic [CAPACITY-1:0] cell_eq;

    logic [NGRP*GRP_SIZE-1:0] eq_pad;
    logic [NGRP-1:0]          grp_hit_reg, grp_hit_next;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        key_t l_key;
        logic l_valid;
        logic l_lt;
        key_t r_key;
        logic r_valid;

        if (i == 0)
        begin : g_first
            // the head sees an always-less, always-valid left side
            assign l_key   = ins_key;
            assign l_valid = 1'b1;
            assign l_lt    = 1'b1;
        end
        else
        begin : g_left
            assign l_key   = cell_key[i-1];
            assign l_valid = cell_valid[i-1];
            assign l_lt    = cell_lt[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign r_key   = cell_key[i];
            assign r_valid = 1'b0;
        end
        else
        begin : g_right
            assign r_key   = cell_key[i+1];
            assign r_valid = cell_valid[i+1];
        end

        sks_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .cmp_key     (cmp_key),
            .ins_key     (ins_key),
            .left_key    (l_key),
            .left_valid  (l_valid),
            .left_lt     (l_lt),
            .right_key   (r_key),
            .right_valid (r_valid),
            .key         (cell_key[i]),
            .valid       (cell_valid[i]),
            .lt          (cell_lt[i]),
            .eq          (cell_eq[i])
        );
    end

    always_comb
    begin
        eq_pad = '0;
        eq_pad[CAPACITY-1:0] = cell_eq;
        for (int g = 0; g < NGRP; g++)
        begin
            grp_hit_next[g] = |eq_pad[g*GRP_SIZE +: GRP_SIZE];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_hit_reg <= '0;
        end
        else
        begin
            grp_hit_reg <= grp_hit_next;
        end
    end

    assign grp_hit = grp_hit_reg;

endmodule

`default_nettype wire

// ===== rtl/core/sorted_key_set_core.sv =====
// Sorted key set: holds up to CAPACITY distinct signed keys in ascending order in a
// chain of cells. Each request item (add, remove, contains, clear) gives one response
// item with a success bit, a full flag and the entry count. All cells compare the
// key at the accepting edge, the match flags are then ored into one registered level
// of groups, and once the response register is free the decision shifts the chain
// and loads the response register. A new item is accepted as soon as the previous
// one has left for the response register; a stalled response holds only the update
// of the item after it.
// Key 2147483647 is never stored.
// depends on sks_pkg, sks_if and sks_chain
`default_nettype none

module sorted_key_set_core
    import sks_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    sks_req_if.sink    req,
    sks_rsp_if.source  rsp
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_REDUCE = 3'b010,
        S_DECIDE = 3'b100
    } state_t;

    state_t state_reg, state_next;
    kind_t  kind_reg, kind_next;
    key_t   key_reg, key_next;
    count_t count_reg, count_next;

    logic                   rsp_valid_reg, rsp_valid_next;
    logic                   rsp_ok_reg, rsp_ok_next;
    logic                   rsp_full_reg, rsp_full_next;
    logic [COUNT_OUT_W-1:0] rsp_count_reg, rsp_count_next;

    cell_cmd_t       cmd;
    cell_op_t        op;
    logic [NGRP-1:0] grp_hit;
    logic            found;
    logic            reserved;
    logic            slot_free;
    logic            accept;
    logic            ok;
    logic            full;
    count_t          count_upd;

    assign accept    = req.valid && req.ready;
    assign found     = |grp_hit;
    assign reserved  = (key_reg == INT_MAX);
    assign slot_free = !rsp_valid_reg || rsp.ready;

    always_comb
    begin
        op        = OP_HOLD;
        ok        = 1'b0;
        full      = 1'b0;
        count_upd = count_reg;
        case (kind_reg)
            KIND_ADD:
            begin
                if (!reserved && !found)
                begin
                    if (count_reg == count_t'(CAPACITY))
                    begin
                        full = 1'b1;
                    end
                    else
                    begin
                        op        = OP_INSERT;
                        ok        = 1'b1;
                        count_upd = count_reg + count_t'(1);
                    end
                end
            end
            KIND_REMOVE:
            begin
                if (!reserved && found)
                begin
                    op        = OP_DELETE;
                    ok        = 1'b1;
                    count_upd = count_reg - count_t'(1);
                end
            end
            KIND_CONTAINS:
            begin
                ok = !reserved && found;
            end
            KIND_CLEAR:
            begin
                op        = OP_CLEAR;
                ok        = 1'b1;
                count_upd = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        key_next       = key_reg;
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_ok_next    = rsp_ok_reg;
        rsp_full_next  = rsp_full_reg;
        rsp_count_next = rsp_count_reg;
        cmd.compare    = accept;
        cmd.op         = OP_HOLD;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    kind_next  = req.kind;
                    key_next   = req.key;
                    state_next = S_REDUCE;
                end
            end
            S_REDUCE:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (slot_free)
                begin
                    cmd.op         = op;
                    count_next     = count_upd;
                    rsp_valid_next = 1'b1;
                    rsp_ok_next    = ok;
                    rsp_full_next  = full;
                    rsp_count_next = COUNT_OUT_W'(count_upd);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        key_reg       <= key_next;
        rsp_ok_reg    <= rsp_ok_next;
        rsp_full_reg  <= rsp_full_next;
        rsp_count_reg <= rsp_count_next;
    end

    // compare uses the key on the port at the accepting edge
    sks_chain u_chain (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .cmp_key (req.key),
        .ins_key (key_reg),
        .grp_hit (grp_hit)
    );

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.success     = rsp_ok_reg;
    assign rsp.full_reject = rsp_full_reg;
    assign rsp.entry_count = rsp_count_reg;

endmodule

`default_nettype wire

// ===== rtl/core/sks_checker.sv =====
// port-level checks of the sorted key set and the bind that attaches them
// depends on sks_pkg, sorted_key_set_core_macros.svh and sorted_key_set_core
`default_nettype none
`include "sorted_key_set_core_macros.svh"

module sks_checker
    import sks_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   req_valid,
    input wire logic                   req_ready,
    input wire logic                   rsp_valid,
    input wire logic                   rsp_ready,
    input wire logic                   rsp_success,
    input wire logic                   rsp_full_reject,
    input wire logic [COUNT_OUT_W-1:0] rsp_entry_count
);

    // a waiting response item keeps its payload
    `SKS_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_entry_count) && $stable(rsp_success) && $stable(rsp_full_reject))

    // one item at a time: no acceptance right after another
    `SKS_ASSERT_NXT(a_one_in_flight, req_valid && req_ready, !req_ready)

    // a refused add never reports success
    `SKS_ASSERT_IMP(a_full_not_ok, rsp_valid && rsp_full_reject, !rsp_success)

    // a full refusal only comes with the set at capacity
    `SKS_ASSERT_IMP(a_full_count, rsp_valid && rsp_full_reject, rsp_entry_count == COUNT_OUT_W'(CAPACITY))

endmodule

bind sorted_key_set_core sks_checker u_sks_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_success     (rsp.success),
    .rsp_full_reject (rsp.full_reject),
    .rsp_entry_count (rsp.entry_count)
);

`default_nettype wire
